@@ hdl/lned_pkg.sv @@
// Shared codes and constants for the line editor with echo.
`default_nettype none

package lned_pkg;

  // Input actions
  localparam logic [1:0] ACT_RX_BYTE   = 2'd0;
  localparam logic [1:0] ACT_READ      = 2'd1;
  localparam logic [1:0] ACT_LINK_LOST = 2'd2;

  // Result kinds
  localparam logic [2:0] KIND_ECHO = 3'd0;
  localparam logic [2:0] KIND_LINE = 3'd1;
  localparam logic [2:0] KIND_RAW  = 3'd2;
  localparam logic [2:0] KIND_DISC = 3'd3;
  localparam logic [2:0] KIND_READ = 3'd4;

  // Characters
  localparam logic [7:0] CH_CR  = 8'h0D;
  localparam logic [7:0] CH_LF  = 8'h0A;
  localparam logic [7:0] CH_DEL = 8'h7F;
  localparam logic [7:0] CH_BS  = 8'h08;
  localparam logic [7:0] CH_SP  = 8'h20;
  localparam logic [7:0] CH_BEL = 8'h07;

  // Register file
  localparam int          PADDR_W        = 3;
  localparam logic        REG_LINE_SIZE  = 1'b0;
  localparam logic [8:0]  LINE_SIZE_RST  = 9'd256;

  // One queued result
  typedef struct packed {
    logic [2:0] kind;
    logic [7:0] data;
    logic [7:0] len;
  } result_t;

endpackage

`default_nettype wire

@@ hdl/lned_mem.sv @@
// Single-port-write, single-port-read synchronous RAM with registered read data.
`default_nettype none

module lned_mem #(
  parameter int DEPTH = 256,
  parameter int WIDTH = 13,
  parameter int AW    = 8
) (
  input  wire logic             clk,
  input  wire logic             we,
  input  wire logic [AW-1:0]    waddr,
  input  wire logic [WIDTH-1:0] wdata,
  input  wire logic             re,
  input  wire logic [AW-1:0]    raddr,
  output logic      [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // read port, registered read data
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

@@ hdl/line_editor_with_echo.sv @@
// Line editor with echo: top level, sequencer and configuration port.
//
// Input channel (in_valid/in_ready): action, data_byte, read_index. One
// transaction is taken at a time; in_ready is high while the block is idle.
// Output channel (out_valid/out_ready): kind, out_byte, line_length, last.
// An input yields zero to three result transactions; last marks the final one.
// Sequence: the accept cycle issues a read of the line memory, the next cycle
// takes the read data, updates the memory and fill count and queues the
// results, and the results then go out in order while out_ready is high.
// No new input is taken until every result of an item has been issued; the
// line memory is read before each update.
// The memory keeps, with every stored byte, the length of the NUL run that
// ends there, so the trailing NUL check costs one read.
// A stalled receiver holds the current result; no input is taken meanwhile.
// Reset (rst, synchronous) clears the fill count, the sequencer and sets
// line_size to 256; the line memory is not cleared. line_size sits at APB
// byte address 0, written in the access phase, and keeps and reads back bits 8:0.
`default_nettype none

module line_editor_with_echo
  import lned_pkg::*;
#(
  parameter int LINE_DEPTH  = 256,
  parameter int RAW_NUL_RUN = 20
) (
  input  wire logic               clk,
  input  wire logic               rst,
  // configuration
  input  wire logic               psel,
  input  wire logic               penable,
  input  wire logic               pwrite,
  input  wire logic [PADDR_W-1:0] paddr,
  input  wire logic [31:0]        pwdata,
  output logic      [31:0]        prdata,
  output logic                    pready,
  // input channel
  input  wire logic               in_valid,
  output logic                    in_ready,
  input  wire logic [1:0]         action,
  input  wire logic [7:0]         data_byte,
  input  wire logic [7:0]         read_index,
  // output channel
  output logic                    out_valid,
  input  wire logic               out_ready,
  output logic      [2:0]         kind,
  output logic      [7:0]         out_byte,
  output logic      [7:0]         line_length,
  output logic                    last
);

  localparam int AW        = $clog2(LINE_DEPTH);
  localparam int RW        = $clog2(RAW_NUL_RUN + 1);
  localparam int MW        = 8 + RW;
  localparam int DEPTH_CAP = (LINE_DEPTH - 1 > 255) ? 255 : LINE_DEPTH - 1;

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_LOOK = 2'd1;
  localparam logic [1:0] ST_EMIT = 2'd2;

  logic [1:0]    state;
  logic [1:0]    state_next;
  logic [8:0]    line_size;
  logic [7:0]    fill_count;
  logic [7:0]    fill_count_next;
  logic [1:0]    op_action;
  logic [7:0]    op_byte;
  logic          op_in_range;
  result_t       res [3];
  result_t       res_next [3];
  logic [1:0]    res_n;
  logic [1:0]    res_n_next;
  logic [1:0]    ptr;

  logic          in_fire;
  logic          out_fire;
  logic          cfg_write;
  logic          mem_we;
  logic [AW-1:0] mem_waddr;
  logic [MW-1:0] mem_wdata;
  logic [AW-1:0] mem_raddr;
  logic [MW-1:0] mem_rdata;
  logic [8:0]    limit;
  logic [RW-1:0] prev_run;
  logic [RW-1:0] new_run;

  assign in_fire   = in_valid && in_ready;
  assign out_fire  = out_valid && out_ready;
  assign cfg_write = psel && penable && pwrite && pready;

  // configuration register
  assign pready = 1'b1;
  assign prdata = (paddr[2] == REG_LINE_SIZE) ? {23'd0, line_size} : 32'd0;

  always_ff @(posedge clk) begin
    if (rst) begin
      line_size <= LINE_SIZE_RST;
    end else if (cfg_write && paddr[2] == REG_LINE_SIZE) begin
      line_size <= pwdata[8:0];
    end
  end

  // line memory: byte plus the NUL run length ending at that entry
  lned_mem #(
    .DEPTH (LINE_DEPTH),
    .WIDTH (MW),
    .AW    (AW)
  ) u_mem (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .re    (in_fire),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

  // read address: stored byte for a read, otherwise the entry below the fill point
  assign mem_raddr = (action == ACT_READ) ? AW'(read_index) : AW'(fill_count - 8'd1);

  // store limit: min(line_size - 1, 255, depth - 1)
  always_comb begin
    limit = (line_size == 9'd0) ? 9'd0 : line_size - 9'd1;
    if (limit > 9'(DEPTH_CAP)) begin
      limit = 9'(DEPTH_CAP);
    end
  end

  // NUL run ending at the new entry, saturating at the raw-mode length
  assign prev_run = (fill_count == 8'd0) ? '0 : mem_rdata[RW-1:0];
  always_comb begin
    if (op_byte != 8'd0) begin
      new_run = '0;
    end else if (prev_run >= RW'(RAW_NUL_RUN)) begin
      new_run = RW'(RAW_NUL_RUN);
    end else begin
      new_run = prev_run + RW'(1);
    end
  end

  // decode the item once the memory data is back
  always_comb begin
    res_next[0]     = res[0];
    res_next[1]     = res[1];
    res_next[2]     = res[2];
    res_n_next      = 2'd0;
    fill_count_next = fill_count;
    mem_we          = 1'b0;
    mem_waddr       = AW'(fill_count);
    mem_wdata       = {op_byte, new_run};
    if (state == ST_LOOK) begin
      res_next[0] = '{kind: KIND_ECHO, data: 8'd0, len: 8'd0};
      res_next[1] = '{kind: KIND_ECHO, data: 8'd0, len: 8'd0};
      res_next[2] = '{kind: KIND_ECHO, data: 8'd0, len: 8'd0};
      unique case (op_action)
        ACT_RX_BYTE: begin
          if (op_byte == CH_CR) begin
            res_next[0].data = CH_CR;
            res_next[1].data = CH_LF;
            res_next[2]      = '{kind: KIND_LINE, data: 8'd0, len: fill_count};
            res_n_next       = 2'd3;
            fill_count_next  = 8'd0;
          end else if (op_byte == CH_DEL) begin
            if (fill_count != 8'd0) begin
              res_next[0].data = CH_BS;
              res_next[1].data = CH_SP;
              res_next[2].data = CH_BS;
              res_n_next       = 2'd3;
              fill_count_next  = fill_count - 8'd1;
            end
          end else if ({1'b0, fill_count} < limit) begin
            res_next[0].data = op_byte;
            mem_we           = 1'b1;
            if (new_run >= RW'(RAW_NUL_RUN)) begin
              res_next[1]     = '{kind: KIND_RAW, data: 8'd0, len: 8'd0};
              res_n_next      = 2'd2;
              fill_count_next = 8'd0;
            end else begin
              res_n_next      = 2'd1;
              fill_count_next = fill_count + 8'd1;
            end
          end else begin
            res_next[0].data = CH_BEL;
            res_n_next       = 2'd1;
          end
        end
        ACT_READ: begin
          res_next[0].kind = KIND_READ;
          res_next[0].data = op_in_range ? mem_rdata[MW-1:RW] : 8'd0;
          res_n_next       = 2'd1;
        end
        ACT_LINK_LOST: begin
          res_next[0].kind = KIND_DISC;
          res_n_next       = 2'd1;
          fill_count_next  = 8'd0;
        end
        default: begin
          res_n_next = 2'd0;
        end
      endcase
    end
  end

  // sequencer
  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: if (in_fire) state_next = ST_LOOK;
      ST_LOOK: state_next = (res_n_next == 2'd0) ? ST_IDLE : ST_EMIT;
      ST_EMIT: if (out_fire && ptr == res_n - 2'd1) state_next = ST_IDLE;
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= ST_IDLE;
      fill_count <= 8'd0;
      ptr        <= 2'd0;
      res_n      <= 2'd0;
    end else begin
      state      <= state_next;
      fill_count <= fill_count_next;
      if (state == ST_LOOK) begin
        res_n <= res_n_next;
        ptr   <= 2'd0;
      end else if (out_fire) begin
        ptr <= ptr + 2'd1;
      end
    end
  end

  // item and result payload
  always_ff @(posedge clk) begin
    if (in_fire) begin
      op_action   <= action;
      op_byte     <= data_byte;
      op_in_range <= (32'(read_index) < LINE_DEPTH);
    end
    res[0] <= res_next[0];
    res[1] <= res_next[1];
    res[2] <= res_next[2];
  end

  // channel outputs
  assign in_ready    = (state == ST_IDLE);
  assign out_valid   = (state == ST_EMIT);
  assign kind        = res[ptr].kind;
  assign out_byte    = res[ptr].data;
  assign line_length = res[ptr].len;
  assign last        = (ptr == res_n - 2'd1);

`ifndef SYNTH
  a_accept_to_look: assert property (@(posedge clk) disable iff (rst)
    in_fire |=> state == ST_LOOK)
    else $error("accepted item did not enter lookup");

  a_fill_in_range: assert property (@(posedge clk) disable iff (rst)
    fill_count <= 8'(DEPTH_CAP))
    else $error("fill count beyond store depth");

  a_last_ends_burst: assert property (@(posedge clk) disable iff (rst)
    out_fire && last |=> !out_valid && in_ready)
    else $error("results continue after last");

  a_write_only_in_look: assert property (@(posedge clk) disable iff (rst)
    mem_we |-> state == ST_LOOK && op_action == ACT_RX_BYTE)
    else $error("line memory written outside update");
`endif

endmodule

`default_nettype wire

@@ sim/tb_line_editor_with_echo.sv @@
// Testbench for line_editor_with_echo: random and directed terminal traffic, scoreboard.
module tb_line_editor_with_echo;
  timeunit 1ns;
  timeprecision 1ps;

  import lned_pkg::*;

  localparam int CLK_PERIOD = 10;
  localparam int LINE_DEPTH = 256;
  localparam int RAW_NUL_RUN = 20;
  localparam logic [PADDR_W-1:0] LINE_SIZE_ADDR = PADDR_W'(4 * REG_LINE_SIZE);
  localparam int IDLE_PCT = 31;
  localparam int SETTLE_CYCLES = 8;
  // Action code with no function: no results, no state change
  localparam logic [1:0] ACT_UNUSED = 2'd3;

  // One expected output transaction
  typedef struct packed {
    logic [2:0] kind;
    logic [7:0] data;
    logic [7:0] len;
    logic       last;
  } echo_result_t;

  // Line discipline predictor and result checker
  class line_echo_scoreboard;
    logic [7:0]   line_mem [LINE_DEPTH];
    bit           mem_written [LINE_DEPTH];
    logic [7:0]   stored_idx [$];
    int unsigned  fill;
    logic [8:0]   line_size;
    echo_result_t exp_q [$];
    int errors, n_in, n_out, n_lines, n_raw, n_bel, n_disc, n_reads, n_erases;

    function new();
      fill = 0;
      line_size = LINE_SIZE_RST;
      errors = 0;
      n_in = 0;
      n_out = 0;
      n_lines = 0;
      n_raw = 0;
      n_bel = 0;
      n_disc = 0;
      n_reads = 0;
      n_erases = 0;
    endfunction

    function void set_line_size(input logic [8:0] v);
      line_size = v;
    endfunction

    function int pending();
      return exp_q.size();
    endfunction

    // Bytes that fit in the line: line_size-1, capped by the store
    function int unsigned store_cap();
      int unsigned lim;
      lim = (line_size >= 1) ? line_size - 1 : 0;
      if (lim > LINE_DEPTH - 1) lim = LINE_DEPTH - 1;
      if (lim > 255) lim = 255;
      return lim;
    endfunction

    function bit trailing_nuls();
      if (fill < RAW_NUL_RUN) return 1'b0;
      for (int unsigned i = fill - RAW_NUL_RUN; i < fill; i++)
        if (line_mem[i] != 8'h00) return 1'b0;
      return 1'b1;
    endfunction

    function void queue_result(input logic [2:0] k, input logic [7:0] b, input logic [7:0] len);
      echo_result_t r;
      r.kind = k;
      r.data = b;
      r.len = len;
      r.last = 1'b0;
      exp_q.push_back(r);
    endfunction

    function logic [7:0] pick_stored_index();
      return stored_idx[$urandom_range(0, stored_idx.size() - 1)];
    endfunction

    // Predict the results of one accepted input transaction
    function void note_input(input logic [1:0] act, input logic [7:0] b, input logic [7:0] idx);
      int n0;
      n0 = exp_q.size();
      n_in++;
      case (act)
        ACT_RX_BYTE: begin
          if (b == CH_CR) begin
            queue_result(KIND_ECHO, CH_CR, 8'h00);
            queue_result(KIND_ECHO, CH_LF, 8'h00);
            queue_result(KIND_LINE, 8'h00, fill[7:0]);
            fill = 0;
            n_lines++;
          end else if (b == CH_DEL) begin
            if (fill > 0) begin
              queue_result(KIND_ECHO, CH_BS, 8'h00);
              queue_result(KIND_ECHO, CH_SP, 8'h00);
              queue_result(KIND_ECHO, CH_BS, 8'h00);
              fill--;
              n_erases++;
            end
          end else if (fill < store_cap()) begin
            queue_result(KIND_ECHO, b, 8'h00);
            line_mem[fill] = b;
            if (!mem_written[fill]) begin
              mem_written[fill] = 1'b1;
              stored_idx.push_back(fill[7:0]);
            end
            fill++;
            if (trailing_nuls()) begin
              queue_result(KIND_RAW, 8'h00, 8'h00);
              fill = 0;
              n_raw++;
            end
          end else begin
            queue_result(KIND_ECHO, CH_BEL, 8'h00);
            n_bel++;
          end
        end
        ACT_READ: begin
          queue_result(KIND_READ, line_mem[idx], 8'h00);
          n_reads++;
        end
        ACT_LINK_LOST: begin
          queue_result(KIND_DISC, 8'h00, 8'h00);
          fill = 0;
          n_disc++;
        end
        default: ;
      endcase
      if (exp_q.size() > n0) exp_q[exp_q.size() - 1].last = 1'b1;
    endfunction

    task report(input string msg);
      errors++;
      if (errors <= 20) $display("[%0t] mismatch: %s", $time, msg);
    endtask

    // Compare one accepted result with the oldest prediction
    task check_result(input logic [2:0] k, input logic [7:0] b, input logic [7:0] len,
                      input logic lst);
      echo_result_t want;
      n_out++;
      if (exp_q.size() == 0) begin
        report($sformatf("unexpected result kind=%0d byte=%02h len=%0d", k, b, len));
        return;
      end
      want = exp_q.pop_front();
      if (k !== want.kind)
        report($sformatf("kind %0d, predicted %0d", k, want.kind));
      if (b !== want.data)
        report($sformatf("out_byte %02h, predicted %02h (kind %0d)", b, want.data, want.kind));
      if (len !== want.len)
        report($sformatf("line_length %0d, predicted %0d", len, want.len));
      if (lst !== want.last)
        report($sformatf("last %b, predicted %b (kind %0d)", lst, want.last, want.kind));
    endtask
  endclass

  logic              clk = 1'b0;
  logic              rst = 1'b1;
  logic              psel = 1'b0;
  logic              penable = 1'b0;
  logic              pwrite = 1'b0;
  logic [PADDR_W-1:0] paddr = '0;
  logic [31:0]       pwdata = '0;
  logic [31:0]       prdata;
  logic              pready;
  logic              in_valid = 1'b0;
  logic              in_ready;
  logic [1:0]        action = ACT_RX_BYTE;
  logic [7:0]        data_byte = 8'h00;
  logic [7:0]        read_index = 8'h00;
  logic              out_valid;
  logic              out_ready = 1'b0;
  logic [2:0]        kind;
  logic [7:0]        out_byte;
  logic [7:0]        line_length;
  logic              last;

  bit stall_en = 1'b1;
  int items_sent = 0;
  line_echo_scoreboard sb = new();

  line_editor_with_echo #(
    .LINE_DEPTH (LINE_DEPTH),
    .RAW_NUL_RUN(RAW_NUL_RUN)
  ) i_dut (
    .clk        (clk),
    .rst        (rst),
    .psel       (psel),
    .penable    (penable),
    .pwrite     (pwrite),
    .paddr      (paddr),
    .pwdata     (pwdata),
    .prdata     (prdata),
    .pready     (pready),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .action     (action),
    .data_byte  (data_byte),
    .read_index (read_index),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .kind       (kind),
    .out_byte   (out_byte),
    .line_length(line_length),
    .last       (last)
  );

  always #(CLK_PERIOD / 2) clk = ~clk;

  // Receiver backpressure
  always @(negedge clk) begin
    out_ready <= stall_en ? ($urandom_range(0, 99) >= IDLE_PCT) : 1'b1;
  end

  // Output monitor
  always @(posedge clk) begin
    if (!rst && out_valid && out_ready)
      sb.check_result(kind, out_byte, line_length, last);
  end

  // Watchdog
  initial begin
    #2_000_000;
    $display("Simulation FAILED");
    $finish;
  end

  // Send one input transaction; entered and left just after a falling edge
  task automatic send_txn(input logic [1:0] act, input logic [7:0] b, input logic [7:0] idx);
    while (stall_en && ($urandom_range(0, 99) < IDLE_PCT)) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    action <= act;
    data_byte <= b;
    read_index <= idx;
    do @(posedge clk); while (!in_ready);
    sb.note_input(act, b, idx);
    if (act != ACT_UNUSED) items_sent++;
    @(negedge clk);
  endtask

  task automatic send_byte(input logic [7:0] b);
    send_txn(ACT_RX_BYTE, b, 8'($urandom_range(0, 255)));
  endtask

  task automatic send_read(input logic [7:0] idx);
    send_txn(ACT_READ, 8'($urandom_range(0, 255)), idx);
  endtask

  task automatic send_link_lost();
    send_txn(ACT_LINK_LOST, 8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)));
  endtask

  // Hold off input until every predicted result has come out
  task automatic drain();
    in_valid <= 1'b0;
    while (sb.pending() != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  // APB write of line_size, setup then access cycle
  task automatic write_line_size(input logic [8:0] v);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= LINE_SIZE_ADDR;
    pwdata <= 32'(v);
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    sb.set_line_size(v);
    @(negedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
  endtask

  // Stimulus
  initial begin
    logic [8:0] phase_size [7];
    int start, r, n, brk;
    phase_size = '{9'd21, 9'd256, 9'd3, 9'd511, 9'd300, 9'd2, 9'd0};

    repeat (4) @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // Directed: empty line, byte extremes, reads, erase, unused action, link loss
    send_byte(CH_DEL);
    send_byte(CH_CR);
    send_byte(8'h00);
    send_byte(8'hFF);
    send_byte(8'h41);
    send_byte(8'h80);
    send_read(8'd1);
    send_read(8'd0);
    send_byte(CH_DEL);
    send_txn(ACT_UNUSED, 8'hA5, 8'h5A);
    send_byte(CH_CR);
    send_read(8'd3);
    send_link_lost();

    // Directed: smallest legal line, then sizes that store nothing
    drain();
    write_line_size(9'd2);
    send_byte(8'h55);
    send_byte(8'h66);
    send_byte(CH_CR);
    drain();
    write_line_size(9'd0);
    send_byte(8'h31);
    send_byte(CH_CR);
    drain();
    write_line_size(9'd1);
    send_byte(8'h32);
    send_byte(CH_DEL);

    // Random phases over several line sizes; first phase runs longer with no stalls
    for (int p = 0; p < 7; p++) begin
      drain();
      write_line_size((p == 6) ? 9'($urandom_range(2, 256)) : phase_size[p]);
      stall_en = (p != 0);
      start = items_sent;
      while (items_sent - start < ((p == 0) ? 24 : 6)) begin
        r = $urandom_range(0, 99);
        if (r < 14) begin
          // NUL run, sometimes from a cleared line, sometimes broken
          if ($urandom_range(0, 1)) send_byte(CH_CR);
          n = $urandom_range(18, 22);
          brk = ($urandom_range(0, 3) == 0) ? $urandom_range(0, n - 1) : -1;
          for (int i = 0; i < n; i++) begin
            if (i == brk)
              send_byte(($urandom_range(0, 1)) ? CH_DEL : 8'($urandom_range(1, 255)));
            else
              send_byte(8'h00);
          end
        end else if (r < 36) begin
          // printable text line ended by CR
          n = $urandom_range(0, 6);
          for (int i = 0; i < n; i++) send_byte(8'($urandom_range(8'h20, 8'h7E)));
          send_byte(CH_CR);
        end else if (r < 56) begin
          send_byte(8'($urandom_range(0, 255)));
        end else if (r < 66) begin
          send_byte(CH_DEL);
        end else if (r < 76) begin
          send_read(sb.pick_stored_index());
        end else if (r < 83) begin
          send_link_lost();
        end else if (r < 87) begin
          send_txn(ACT_UNUSED, 8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)));
        end else begin
          send_byte(CH_CR);
        end
        // let the output side catch up once mid-phase
        if (p == 3 && items_sent - start == 3) drain();
      end
    end

    // Wait for the tail of the output stream
    stall_en = 1'b1;
    drain();
    $display("Ran %0d input transactions and %0d results over 10 line_size settings",
             sb.n_in, sb.n_out);
    $display("Saw %0d lines, %0d raw-mode requests, %0d BELs, %0d erases, %0d reads, %0d drops",
             sb.n_lines, sb.n_raw, sb.n_bel, sb.n_erases, sb.n_reads, sb.n_disc);
    if (sb.errors == 0 && sb.pending() == 0)
      $display("Simulation PASSED");
    else
      $display("Simulation FAILED");
    $finish;
  end

endmodule
